>>> sv/dpd_pkg.sv
// ----------------------------------------------------------------------------
// dpd_pkg: shared types and constants
// Configuration register indexes, reset values, the candidate direction
// code and the configuration bundle for the position debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package dpd_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int HYST_BITS = 15;
  localparam int DEB_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FWD_HYST = 2'd0,
    CFG_REW_HYST = 2'd1,
    CFG_FWD_DEB  = 2'd2,
    CFG_REW_DEB  = 2'd3
  } cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [HYST_BITS-1:0] FWD_HYST_RST = 15'd2;
  localparam logic [HYST_BITS-1:0] REW_HYST_RST = 15'd2;
  localparam logic [DEB_BITS-1:0]  FWD_DEB_RST  = 16'd20;
  localparam logic [DEB_BITS-1:0]  REW_DEB_RST  = 16'd20;

  // Candidate direction.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  // Configuration bundle passed to the filter.
  typedef struct packed {
    logic [HYST_BITS-1:0] fwd_hyst;
    logic [HYST_BITS-1:0] rew_hyst;
    logic [DEB_BITS-1:0]  fwd_deb;
    logic [DEB_BITS-1:0]  rew_deb;
  } cfg_t;

endpackage

`default_nettype wire

>>> sv/dpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// dpd_cfg_regs: configuration registers
// Holds the hysteresis and debounce settings, written through a plain
// write port.
// ----------------------------------------------------------------------------
`default_nettype none

module dpd_cfg_regs import dpd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                          cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write into the addressed register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FWD_HYST: cfg_nxt.fwd_hyst = cfg_data[HYST_BITS-1:0];
        CFG_REW_HYST: cfg_nxt.rew_hyst = cfg_data[HYST_BITS-1:0];
        CFG_FWD_DEB:  cfg_nxt.fwd_deb  = cfg_data[DEB_BITS-1:0];
        CFG_REW_DEB:  cfg_nxt.rew_deb  = cfg_data[DEB_BITS-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register bank with reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fwd_hyst <= FWD_HYST_RST;
      cfg_r.rew_hyst <= REW_HYST_RST;
      cfg_r.fwd_deb  <= FWD_DEB_RST;
      cfg_r.rew_deb  <= REW_DEB_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> sv/dpd_filter.sv
// ----------------------------------------------------------------------------
// dpd_filter: debounce state and update logic
// Holds the stable position and the candidate, and updates them for one
// item per cycle when step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module dpd_filter import dpd_pkg::*; #(
  parameter int POSITION_BITS = 16,
  parameter int TIME_BITS     = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,
  input  wire logic                     cmd,
  input  wire logic [POSITION_BITS-1:0] raw_pos,
  input  wire logic [TIME_BITS-1:0]     now_ms,
  input  wire logic                     rewind_ok,
  input  wire cfg_t                     cfg,
  output logic                          changed,
  output logic [POSITION_BITS-2:0]      stable_pos
);

  localparam int SW   = POSITION_BITS - 1;
  localparam int CMPW = (SW > HYST_BITS) ? SW : HYST_BITS;

  logic                 init_r;
  logic [SW-1:0]        stable_r;
  logic [SW-1:0]        stable_nxt;
  dir_t                 dir_r;
  dir_t                 dir_nxt;
  logic [TIME_BITS-1:0] since_r;
  logic [TIME_BITS-1:0] since_nxt;

  logic                 restart;
  logic [SW-1:0]        pos;
  logic [SW-1:0]        base_stable;
  dir_t                 base_dir;
  logic [TIME_BITS-1:0] base_since;
  logic                 fwd;
  dir_t                 move_dir;
  logic [SW-1:0]        mag;
  logic [HYST_BITS-1:0] hyst;
  logic [DEB_BITS-1:0]  deb;
  logic [TIME_BITS-1:0] elapsed;

  // Clamp negative positions to zero.
  assign pos = raw_pos[POSITION_BITS-1] ? '0 : raw_pos[SW-1:0];

  // A reset command, or the first update, restarts the filter.
  assign restart     = cmd | ~init_r;
  assign base_stable = restart ? pos : stable_r;
  assign base_dir    = restart ? DIR_NONE : dir_r;
  assign base_since  = restart ? now_ms : since_r;

  // Direction, size and thresholds of the move.
  assign fwd      = pos > base_stable;
  assign move_dir = fwd ? DIR_FWD : DIR_BACK;
  assign mag      = fwd ? (pos - base_stable) : (base_stable - pos);
  assign hyst     = fwd ? cfg.fwd_hyst : cfg.rew_hyst;
  assign deb      = fwd ? cfg.fwd_deb : cfg.rew_deb;
  assign elapsed  = now_ms - base_since;

  // Next state and result for the item.
  always_comb begin
    stable_nxt = base_stable;
    dir_nxt    = base_dir;
    since_nxt  = base_since;
    changed    = 1'b0;
    if (!cmd) begin
      if (pos == base_stable) begin
        dir_nxt   = DIR_NONE;
        since_nxt = now_ms;
      end else if (!fwd && !rewind_ok) begin
        dir_nxt   = DIR_NONE;
        since_nxt = now_ms;
      end else if (CMPW'(mag) < CMPW'(hyst)) begin
        dir_nxt   = DIR_NONE;
        since_nxt = now_ms;
      end else if (base_dir != move_dir) begin
        dir_nxt   = move_dir;
        since_nxt = now_ms;
      end else if (elapsed >= TIME_BITS'(deb)) begin
        stable_nxt = pos;
        dir_nxt    = DIR_NONE;
        since_nxt  = now_ms;
        changed    = 1'b1;
      end
    end
  end

  assign stable_pos = stable_nxt;

  // Filter state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r   <= 1'b0;
      stable_r <= '0;
      dir_r    <= DIR_NONE;
      since_r  <= '0;
    end else if (step) begin
      init_r   <= 1'b1;
      stable_r <= stable_nxt;
      dir_r    <= dir_nxt;
      since_r  <= since_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/directional_position_debouncer.sv
// ----------------------------------------------------------------------------
// directional_position_debouncer: encoder position debouncer
// Qualifies a raw encoder position with per-direction hysteresis and
// debounce time.
//
// Usage: items enter on the in_ channel (in_valid / in_stall) and each one
// produces exactly one result item on the out_ channel (out_valid /
// out_stall). An item is taken on a rising edge with valid high and stall
// low. An accepted item is held in an input register; when the output
// register is free, the filter updates its state and the result is loaded
// into the output register, where it can be taken while out_valid is high.
// One item is taken every cycle while the receiver does not stall; the state
// update is a single compare-and-select pass between the input and output
// registers.
// When the receiver stalls, the result stays in the output register and the
// input register still takes one more item, after which in_stall rises.
// Configuration is to be written through cfg_we / cfg_index / cfg_data while
// the block is idle; the block does not enforce this. Synchronous reset
// empties both registers, loads the default settings and leaves the filter
// uninitialized: the first update restarts it at its own position.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_position_debouncer import dpd_pkg::*; #(
  parameter int POSITION_BITS = 16,
  parameter int TIME_BITS     = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_cmd,
  input  wire logic [POSITION_BITS-1:0] in_raw_pos,
  input  wire logic [TIME_BITS-1:0]     in_now_ms,
  input  wire logic                     in_rewind_ok,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_changed,
  output logic [POSITION_BITS-2:0]      out_stable_pos,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t cfg;

  logic                     s1_valid_r;
  logic                     s1_cmd_r;
  logic [POSITION_BITS-1:0] s1_pos_r;
  logic [TIME_BITS-1:0]     s1_now_r;
  logic                     s1_rew_r;
  logic                     out_valid_r;
  logic                     out_changed_r;
  logic [POSITION_BITS-2:0] out_stable_r;

  logic                     out_free;
  logic                     step;
  logic                     in_take;
  logic                     f_changed;
  logic [POSITION_BITS-2:0] f_stable;

  // Handshake control.
  assign out_free = ~out_valid_r | ~out_stall;
  assign step     = s1_valid_r & out_free;
  assign in_stall = s1_valid_r & ~out_free;
  assign in_take  = in_valid & ~in_stall;

  dpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpd_filter #(
    .POSITION_BITS (POSITION_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .cmd        (s1_cmd_r),
    .raw_pos    (s1_pos_r),
    .now_ms     (s1_now_r),
    .rewind_ok  (s1_rew_r),
    .cfg        (cfg),
    .changed    (f_changed),
    .stable_pos (f_stable)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (out_free || !s1_valid_r) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r <= in_cmd;
      s1_pos_r <= in_raw_pos;
      s1_now_r <= in_now_ms;
      s1_rew_r <= in_rewind_ok;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_changed_r <= f_changed;
      out_stable_r  <= f_stable;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_changed    = out_changed_r;
  assign out_stable_pos = out_stable_r;

endmodule

`default_nettype wire
